// File: rtl/core/krpc_pkg.sv
// Package for the Koch region pixel classifier: shared types, region codes
// and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package krpc_pkg;

    // Width of the iteration limit register, of the input fields and of the region code.
    localparam int CFG_W  = 4;
    localparam int X_W    = 16;
    localparam int Y_W    = 18;
    localparam int CLS_W  = 2;

    // Defaults for the top-level parameters.
    localparam int MAX_ITER_DEF  = 12;
    localparam int FRAC_BITS_DEF = 24;

    // Reset value of the iteration limit.
    localparam logic [CFG_W-1:0] LIMIT_RESET = 4'd8;

    // 1/sqrt(3) as unsigned Q0.44, split into two halves for the multiplier.
    localparam int                 INV_W         = 44;
    localparam int                 SPLIT         = 22;
    localparam logic [INV_W-1:0]   INV_SQRT3_Q44 = 44'd10156853348378;
    localparam logic [SPLIT-1:0]   INV_LO        = INV_SQRT3_Q44[SPLIT-1:0];
    localparam logic [INV_W-SPLIT-1:0] INV_HI    = INV_SQRT3_Q44[INV_W-1:SPLIT];

    // Partial product width and full product width (Q2.60 fits in 62 bits).
    localparam int PP_W   = Y_W + SPLIT;
    localparam int PROD_W = Y_W + INV_W;

    // Region codes.
    typedef enum logic [CLS_W-1:0] {
        REGION_INSIDE    = 2'd0,
        REGION_OUTSIDE   = 2'd1,
        REGION_CORNER    = 2'd2,
        REGION_UNDECIDED = 2'd3
    } t_region;

    // Control that travels alongside each pixel through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             done;
        t_region          cls;
        logic [CFG_W-1:0] limit;
    } t_ctl;

endpackage

// File: rtl/core/krpc_front.sv
// Coordinate front end: converts the pixel position into triangular
// coordinates t and s. Depends on krpc_pkg.
`timescale 1ns / 1ps

module krpc_front
    import krpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int W         = FRAC_BITS + 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [X_W-1:0]      i_x_pos,
    input  logic [Y_W-1:0]      i_y_pos,
    input  logic [CFG_W-1:0]    i_limit,
    output t_ctl                o_ctl,
    output logic signed [W-1:0] o_t,
    output logic signed [W-1:0] o_s
);

    localparam int YQ_W = FRAC_BITS + 3;

    t_ctl                r1_ctl, r2_ctl, r3_ctl;
    logic [X_W-1:0]      r1_x, r2_x;
    logic [PP_W-1:0]     r1_plo, r1_phi;
    logic [YQ_W-1:0]     r2_yq;
    logic signed [W-1:0] r3_t, r3_s;

    logic [PROD_W:0]     n_prod;
    logic [YQ_W-1:0]     n_yq;
    logic signed [W-1:0] n_xf, n_yd, n_one;
    t_ctl                n_ctl;

    // Incoming control word: nothing decided yet.
    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.done  = 1'b0;
        n_ctl.cls   = REGION_UNDECIDED;
        n_ctl.limit = i_limit;
    end

    // Full product from the two partial products, rounded half up.
    always_comb begin
        n_prod = ((PROD_W+1)'(r1_phi) << SPLIT) + (PROD_W+1)'(r1_plo)
               + ((PROD_W+1)'(1) << (59 - FRAC_BITS));
        n_yq   = YQ_W'(n_prod >> (60 - FRAC_BITS));
    end

    // Triangular coordinates.
    always_comb begin
        n_xf  = signed'(W'(r2_x)) <<< (FRAC_BITS - X_W);
        n_yd  = signed'(W'(r2_yq));
        n_one = signed'(W'(1)) <<< FRAC_BITS;
    end

    // Control valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl.valid <= n_ctl.valid;
            r2_ctl.valid <= r1_ctl.valid;
            r3_ctl.valid <= r2_ctl.valid;
        end
    end

    // Payload stages: partial products, rounded y/sqrt3, then t and s.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl.done  <= n_ctl.done;
            r1_ctl.cls   <= n_ctl.cls;
            r1_ctl.limit <= n_ctl.limit;
            r1_x         <= i_x_pos;
            r1_plo       <= PP_W'(i_y_pos) * PP_W'(INV_LO);
            r1_phi       <= PP_W'(i_y_pos) * PP_W'(INV_HI);

            r2_ctl.done  <= r1_ctl.done;
            r2_ctl.cls   <= r1_ctl.cls;
            r2_ctl.limit <= r1_ctl.limit;
            r2_x         <= r1_x;
            r2_yq        <= n_yq;

            r3_ctl.done  <= r2_ctl.done;
            r3_ctl.cls   <= r2_ctl.cls;
            r3_ctl.limit <= r2_ctl.limit;
            r3_t         <= n_one - n_xf - n_yd;
            r3_s         <= n_xf - n_yd;
        end
    end

    assign o_ctl = r3_ctl;
    assign o_t   = r3_t;
    assign o_s   = r3_s;

endmodule

// File: rtl/core/krpc_cell.sv
// One refinement round of the classifier: decision tests and the zoom map
// into a sub-triangle. Depends on krpc_pkg.
`timescale 1ns / 1ps

module krpc_cell
    import krpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int W         = FRAC_BITS + 5,
    parameter int CELL_IDX  = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_ctl                i_ctl,
    input  logic signed [W-1:0] i_t,
    input  logic signed [W-1:0] i_s,
    output t_ctl                o_ctl,
    output logic signed [W-1:0] o_t,
    output logic signed [W-1:0] o_s
);

    localparam int CW = W + 4;

    t_ctl                 r_ctl;
    logic signed [W-1:0]  r_t, r_s;

    logic signed [CW-1:0] n_te, n_se, n_sum, n_sum3, n_t3, n_s3;
    logic signed [CW-1:0] n_one, n_two, n_nt, n_ns;
    logic                 n_at_limit;
    t_ctl                 n_ctl;

    // Sign-extended operands and their multiples of three.
    always_comb begin
        n_te   = CW'(i_t);
        n_se   = CW'(i_s);
        n_one  = signed'(CW'(1)) <<< FRAC_BITS;
        n_two  = signed'(CW'(2)) <<< FRAC_BITS;
        n_sum  = n_te + n_se;
        n_sum3 = n_sum + n_sum + n_sum;
        n_t3   = n_te + n_te + n_te;
        n_s3   = n_se + n_se + n_se;
        n_at_limit = (32'(i_ctl.limit) == CELL_IDX);
    end

    // Decision tests, in priority order.
    always_comb begin
        n_ctl = i_ctl;
        if (i_ctl.valid && !i_ctl.done) begin
            if (n_sum > n_one) begin
                n_ctl.done = 1'b1;
                n_ctl.cls  = REGION_INSIDE;
            end else if (n_te <= 0 || n_se <= 0) begin
                n_ctl.done = 1'b1;
                n_ctl.cls  = REGION_OUTSIDE;
            end else if (n_sum3 < n_two) begin
                n_ctl.done = 1'b1;
                n_ctl.cls  = REGION_CORNER;
            end else if (n_at_limit) begin
                n_ctl.done = 1'b1;
                n_ctl.cls  = REGION_UNDECIDED;
            end
        end
    end

    // Zoom map into one of four sub-triangles.
    always_comb begin
        if (n_s3 >= n_two) begin
            n_nt = n_t3;
            n_ns = n_s3 - n_two;
        end else if (n_t3 >= n_two) begin
            n_nt = n_t3 - n_two;
            n_ns = n_s3;
        end else if (n_t3 <= n_one) begin
            n_nt = n_t3 - n_two + n_s3;
            n_ns = n_two - n_s3;
        end else begin
            n_nt = n_two - n_t3;
            n_ns = n_s3 - n_two + n_t3;
        end
    end

    // Control valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= n_ctl.valid;
        end
    end

    // Payload: coordinates always pass through the map; once a pixel is
    // decided they are no longer looked at.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.done  <= n_ctl.done;
            r_ctl.cls   <= n_ctl.cls;
            r_ctl.limit <= n_ctl.limit;
            r_t         <= W'(n_nt);
            r_s         <= W'(n_ns);
        end
    end

    assign o_ctl = r_ctl;
    assign o_t   = r_t;
    assign o_s   = r_s;

endmodule

// File: rtl/core/koch_region_pixel_classifier.sv
// Top level of the Koch region pixel classifier: limit register, front end,
// chain of refinement cells and output register. Depends on krpc_pkg,
// krpc_front and krpc_cell.
`timescale 1ns / 1ps

// Usage:
// - Input channel (i_valid / o_stall, i_x_pos, i_y_pos): one pixel position
//   per transaction, x as Q0.16 and y as Q2.16, both divided by image width.
// - Output channel (o_valid / i_stall, o_region_class, o_pixel_bit): one
//   result per pixel, in input order.
// - Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data): writes
//   the iteration limit; always ready. Write it only while the block is idle.
// - Pipeline: three front-end stages (split multiply, rounding, coordinate
//   subtract), one cell per round (MAX_ITER + 1 cells) and the output
//   register. One pixel is accepted per cycle while o_stall is low.
// - The whole pipeline advances together; when the output holds a result
//   and the receiver stalls, o_stall rises and every stage keeps its data.
// - Synchronous reset empties the pipeline and sets the iteration limit
//   back to 8.
module koch_region_pixel_classifier
    import krpc_pkg::*;
#(
    parameter int MAX_ITER  = MAX_ITER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [X_W-1:0]     i_x_pos,
    input  logic [Y_W-1:0]     i_y_pos,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CLS_W-1:0]   o_region_class,
    output logic               o_pixel_bit,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int W      = FRAC_BITS + 5;
    localparam int NCELLS = MAX_ITER + 1;

    logic [CFG_W-1:0]    r_limit;
    logic [CFG_W-1:0]    n_limit_eff;
    logic                w_en;
    logic                r_out_valid;
    t_region             r_out_cls;

    t_ctl                w_ctl [0:NCELLS];
    logic signed [W-1:0] w_t   [0:NCELLS];
    logic signed [W-1:0] w_s   [0:NCELLS];

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // The effective limit saturates at MAX_ITER.
    always_comb begin
        if (32'(r_limit) > MAX_ITER) begin
            n_limit_eff = CFG_W'(MAX_ITER);
        end else begin
            n_limit_eff = r_limit;
        end
    end

    // Pipeline advances unless a finished result is held by the receiver.
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    krpc_front #(
        .FRAC_BITS (FRAC_BITS),
        .W         (W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x_pos (i_x_pos),
        .i_y_pos (i_y_pos),
        .i_limit (n_limit_eff),
        .o_ctl   (w_ctl[0]),
        .o_t     (w_t[0]),
        .o_s     (w_s[0])
    );

    // One cell per round.
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        krpc_cell #(
            .FRAC_BITS (FRAC_BITS),
            .W         (W),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_t     (w_t[g]),
            .i_s     (w_s[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_t     (w_t[g+1]),
            .o_s     (w_s[g+1])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctl[NCELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_cls <= w_ctl[NCELLS].done ? w_ctl[NCELLS].cls : REGION_UNDECIDED;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_region_class = r_out_cls;
    assign o_pixel_bit    = (r_out_cls == REGION_INSIDE);

    // The last cell's trailing coordinates are not used further.
    logic w_unused;
    assign w_unused = ^{w_t[NCELLS], w_s[NCELLS], w_ctl[NCELLS].limit};

endmodule
